FILE: src/environment_sensor_compensation_unit_defines.svh
// Assertion macros shared by the compensation unit's RTL files.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ENVIRONMENT_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define ENVIRONMENT_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ESCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/escu_pkg.sv
// Package of the environment sensor compensation unit.
// Holds the item, result and calibration types, register indexes and states.
// No dependencies.
package escu_pkg;

  // One raw sample triple.
  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } escu_in_t;

  // One compensated result.
  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic        [31:0] pressure_q8;
    logic        [16:0] humidity_q10;
  } escu_out_t;

  // Calibration registers as seen by the datapath.
  typedef struct packed {
    logic        [47:0] temp_calib;
    logic        [63:0] press_calib_low;
    logic        [63:0] press_calib_high;
    logic signed [15:0] press_calib_last;
    logic        [63:0] hum_calib;
    logic               humidity_enable;
  } escu_cfg_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CALIB       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_LAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_CALIB        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY_ENABLE  = 3'd5;

  // Sequencer states of the compute engine.
  typedef enum logic [4:0] {
    S_IDLE,
    S_T1, S_T2, S_T3, S_T4,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_DIV,
    S_P8, S_P9, S_P10,
    S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8,
    S_OUT
  } escu_state_t;

endpackage

FILE: src/escu_front.sv
// Front end of the compensation unit: accepts items and queues them.
// Depends on escu_pkg.
module escu_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  escu_pkg::escu_in_t in_data,
  output logic             q_valid,
  output escu_pkg::escu_in_t q_item,
  input  logic             q_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  escu_pkg::escu_in_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push, pop;

  // The queue is full when every entry holds an item.
  assign busy    = (count_r == CW'(DEPTH));
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

FILE: src/escu_mul.sv
// Multi-cycle 64 by 64 bit multiplier giving the low 64 bits of the product.
// Uses one 32 by 32 bit multiplier over three partial products; no dependencies.
module escu_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        busy,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] a_r, b_r, pp_r, acc_r;
  logic [1:0]  cnt_r;
  logic        busy_r, done_r;

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

  // Control: busy while the counter steps through the partial products after start, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial products: low by low, then the two cross terms shifted by 32.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      case (cnt_r)
        2'd0: pp_r <= a_r[31:0] * b_r[31:0];
        2'd1: begin
          acc_r <= pp_r;
          pp_r  <= a_r[31:0] * b_r[63:32];
        end
        2'd2: begin
          acc_r <= acc_r + {pp_r[31:0], 32'b0};
          pp_r  <= a_r[63:32] * b_r[31:0];
        end
        2'd3: acc_r <= acc_r + {pp_r[31:0], 32'b0};
        default: ;
      endcase
    end
  end

endmodule

FILE: src/escu_div.sv
// Signed 64-bit divider, quotient truncated toward zero, two bits per cycle.
// Restoring division on magnitudes; no dependencies.
module escu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0]  rem_r, quo_r, den_r;
  logic         neg_r, busy_r, done_r;
  logic [4:0]   cnt_r;
  logic [127:0] s1, s2;

  // One restoring step: returns the new remainder and the shifted quotient.
  function automatic logic [127:0] div_step(input logic [63:0] rem,
                                            input logic [63:0] q,
                                            input logic [63:0] d);
    logic [64:0] t;
    logic [64:0] diff;
    t    = {rem, q[63]};
    diff = t - {1'b0, d};
    if (!diff[64]) begin
      div_step = {diff[63:0], q[62:0], 1'b1};
    end else begin
      div_step = {t[63:0], q[62:0], 1'b0};
    end
  endfunction

  assign s1   = div_step(rem_r, quo_r, den_r);
  assign s2   = div_step(s1[127:64], s1[63:0], den_r);
  assign done = done_r;
  assign quo  = neg_r ? (64'd0 - quo_r) : quo_r;

  // Control: 32 iterations after start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitudes on start, two quotient bits per busy cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[63] ^ den[63];
      quo_r <= num[63] ? (64'd0 - num) : num;
      den_r <= den[63] ? (64'd0 - den) : den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= s2[127:64];
      quo_r <= s2[63:0];
    end
  end

endmodule

FILE: src/escu_back.sv
// Back end of the compensation unit: sequences temperature, pressure and humidity.
// Depends on escu_pkg, escu_mul, escu_div and the assertion macro header.
`include "environment_sensor_compensation_unit_defines.svh"
module escu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  escu_pkg::escu_cfg_t  cfg,
  input  logic                q_valid,
  input  escu_pkg::escu_in_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  output escu_pkg::escu_out_t  out_data
);

  escu_pkg::escu_state_t st_r, st_nxt;
  logic        pend_r, pend_nxt;
  logic [19:0] raw_p_r, raw_t_r;
  logic [15:0] raw_h_r;
  logic [31:0] ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt;
  logic [31:0] tf_r, tf_nxt, temp_r, temp_nxt, pres_r, pres_nxt;
  logic [16:0] hum_r, hum_nxt;
  logic [63:0] sq_r, sq_nxt, v2_r, v2_nxt, w_r, w_nxt, dv_r, dv_nxt, p_r, p_nxt;
  logic        out_valid_r, out_valid_nxt;
  escu_pkg::escu_out_t out_data_r, out_data_nxt;

  logic        is_mul, mul_start, mul_busy, mul_done;
  logic [63:0] mul_a, mul_b, prod;
  logic [31:0] prod32;
  logic        div_start, div_done;
  logic [63:0] div_q;

  // Calibration fields.
  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p5, p6, p8, p9, p4_sh, p7_sh;
  logic [31:0] tm_a, tm_d, x_h, rc15, h_base;
  logic [63:0] v1_w, ph13, p_base, num_a;

  assign t1 = {16'b0, cfg.temp_calib[15:0]};
  assign t2 = {{16{cfg.temp_calib[31]}}, cfg.temp_calib[31:16]};
  assign t3 = {{16{cfg.temp_calib[47]}}, cfg.temp_calib[47:32]};
  assign p1 = {48'b0, cfg.press_calib_low[15:0]};
  assign p2 = {{48{cfg.press_calib_low[31]}}, cfg.press_calib_low[31:16]};
  assign p3 = {{48{cfg.press_calib_low[47]}}, cfg.press_calib_low[47:32]};
  assign p4_sh = {{13{cfg.press_calib_low[63]}}, cfg.press_calib_low[63:48], 35'b0};
  assign p5 = {{48{cfg.press_calib_high[15]}}, cfg.press_calib_high[15:0]};
  assign p6 = {{48{cfg.press_calib_high[31]}}, cfg.press_calib_high[31:16]};
  assign p7_sh = {{44{cfg.press_calib_high[47]}}, cfg.press_calib_high[47:32], 4'b0};
  assign p8 = {{48{cfg.press_calib_high[63]}}, cfg.press_calib_high[63:48]};
  assign p9 = {{48{cfg.press_calib_last[15]}}, cfg.press_calib_last};
  assign h1 = {24'b0, cfg.hum_calib[7:0]};
  assign h2 = {{16{cfg.hum_calib[23]}}, cfg.hum_calib[23:8]};
  assign h3 = {24'b0, cfg.hum_calib[31:24]};
  assign h4 = {{20{cfg.hum_calib[43]}}, cfg.hum_calib[43:32]};
  assign h5 = {{20{cfg.hum_calib[55]}}, cfg.hum_calib[55:44]};
  assign h6 = {{24{cfg.hum_calib[63]}}, cfg.hum_calib[63:56]};

  // Operand terms built from stored values.
  assign tm_a   = {15'b0, raw_t_r[19:3]} - {15'b0, t1[15:0], 1'b0};
  assign tm_d   = {16'b0, raw_t_r[19:4]} - t1;
  assign v1_w   = {{32{tf_r[31]}}, tf_r} - 64'd128000;
  assign x_h    = tf_r - 32'd76800;
  assign rc15   = 32'($signed(rc_r) >>> 15);
  assign ph13   = 64'($signed(p_r) >>> 13);
  assign p_base = 64'd1048576 - {44'b0, raw_p_r};
  assign num_a  = {p_base[32:0], 31'b0} - v2_r;
  assign h_base = {2'b0, raw_h_r, 14'b0} - {h4[11:0], 20'b0};
  assign prod32 = prod[31:0];

  escu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  escu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sq_r),
    .den   (dv_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Multiplier operands for each step.
  always_comb begin
    is_mul = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (st_r)
      escu_pkg::S_T1:  begin mul_a = {32'b0, tm_a};  mul_b = {32'b0, t2};  end
      escu_pkg::S_T2:  begin mul_a = {32'b0, tm_d};  mul_b = {32'b0, tm_d}; end
      escu_pkg::S_T3:  begin mul_a = {32'b0, rb_r};  mul_b = {32'b0, t3};  end
      escu_pkg::S_T4:  begin mul_a = {32'b0, tf_r};  mul_b = 64'd5;        end
      escu_pkg::S_P1:  begin mul_a = v1_w;           mul_b = v1_w;         end
      escu_pkg::S_P2:  begin mul_a = sq_r;           mul_b = p6;           end
      escu_pkg::S_P3:  begin mul_a = v1_w;           mul_b = p5;           end
      escu_pkg::S_P4:  begin mul_a = sq_r;           mul_b = p3;           end
      escu_pkg::S_P5:  begin mul_a = v1_w;           mul_b = p2;           end
      escu_pkg::S_P6:  begin mul_a = 64'h0000_8000_0000_0000 + w_r; mul_b = p1; end
      escu_pkg::S_P7:  begin mul_a = num_a;          mul_b = 64'd3125;     end
      escu_pkg::S_P8:  begin mul_a = p9;             mul_b = ph13;         end
      escu_pkg::S_P9:  begin mul_a = sq_r;           mul_b = ph13;         end
      escu_pkg::S_P10: begin mul_a = p8;             mul_b = p_r;          end
      escu_pkg::S_H1:  begin mul_a = {32'b0, h5};    mul_b = {32'b0, x_h}; end
      escu_pkg::S_H2:  begin mul_a = {32'b0, x_h};   mul_b = {32'b0, h6};  end
      escu_pkg::S_H3:  begin mul_a = {32'b0, x_h};   mul_b = {32'b0, h3};  end
      escu_pkg::S_H4:  begin mul_a = {32'b0, rb_r};  mul_b = {32'b0, rc_r}; end
      escu_pkg::S_H5:  begin mul_a = {32'b0, rb_r};  mul_b = {32'b0, h2};  end
      escu_pkg::S_H6:  begin mul_a = {32'b0, ra_r};  mul_b = {32'b0, rb_r}; end
      escu_pkg::S_H7:  begin mul_a = {32'b0, rc15};  mul_b = {32'b0, rc15}; end
      escu_pkg::S_H8:  begin mul_a = {32'b0, rb_r};  mul_b = {32'b0, h1};  end
      default:         is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !pend_r;
  assign div_start = (st_r == escu_pkg::S_DIV) && !pend_r;

  // Next state and result commit for each step.
  always_comb begin
    logic [31:0] xf;
    logic [63:0] psum;
    logic        commit;
    escu_pkg::escu_state_t hum_next;

    st_nxt        = st_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    tf_nxt        = tf_r;
    temp_nxt      = temp_r;
    pres_nxt      = pres_r;
    hum_nxt       = hum_r;
    sq_nxt        = sq_r;
    v2_nxt        = v2_r;
    w_nxt         = w_r;
    dv_nxt        = dv_r;
    p_nxt         = p_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    xf            = rc_r - 32'($signed(prod32) >>> 4);
    psum          = p_r + w_r + 64'($signed(prod) >>> 19);
    commit        = is_mul && mul_done;
    hum_next      = cfg.humidity_enable ? escu_pkg::S_H1 : escu_pkg::S_OUT;

    // Handshake with the multiplier and divider.
    if (mul_start || div_start) begin
      pend_nxt = 1'b1;
    end else if (mul_done || div_done) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end

    case (st_r)
      escu_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = escu_pkg::S_T1;
        end
      end
      escu_pkg::S_T1: if (commit) begin
        ra_nxt = 32'($signed(prod32) >>> 11);
        st_nxt = escu_pkg::S_T2;
      end
      escu_pkg::S_T2: if (commit) begin
        rb_nxt = 32'($signed(prod32) >>> 12);
        st_nxt = escu_pkg::S_T3;
      end
      escu_pkg::S_T3: if (commit) begin
        tf_nxt = ra_r + 32'($signed(prod32) >>> 14);
        st_nxt = escu_pkg::S_T4;
      end
      escu_pkg::S_T4: if (commit) begin
        temp_nxt = 32'($signed(prod32 + 32'd128) >>> 8);
        st_nxt   = escu_pkg::S_P1;
      end
      escu_pkg::S_P1: if (commit) begin
        sq_nxt = prod;
        st_nxt = escu_pkg::S_P2;
      end
      escu_pkg::S_P2: if (commit) begin
        v2_nxt = prod;
        st_nxt = escu_pkg::S_P3;
      end
      escu_pkg::S_P3: if (commit) begin
        v2_nxt = v2_r + {prod[46:0], 17'b0} + p4_sh;
        st_nxt = escu_pkg::S_P4;
      end
      escu_pkg::S_P4: if (commit) begin
        w_nxt  = 64'($signed(prod) >>> 8);
        st_nxt = escu_pkg::S_P5;
      end
      escu_pkg::S_P5: if (commit) begin
        w_nxt  = w_r + {prod[51:0], 12'b0};
        st_nxt = escu_pkg::S_P6;
      end
      escu_pkg::S_P6: if (commit) begin
        dv_nxt = 64'($signed(prod) >>> 33);
        // A zero divisor gives a zero pressure.
        if (dv_nxt == 64'd0) begin
          pres_nxt = '0;
          st_nxt   = hum_next;
        end else begin
          st_nxt = escu_pkg::S_P7;
        end
      end
      escu_pkg::S_P7: if (commit) begin
        sq_nxt = prod;
        st_nxt = escu_pkg::S_DIV;
      end
      escu_pkg::S_DIV: if (div_done) begin
        p_nxt  = div_q;
        st_nxt = escu_pkg::S_P8;
      end
      escu_pkg::S_P8: if (commit) begin
        sq_nxt = prod;
        st_nxt = escu_pkg::S_P9;
      end
      escu_pkg::S_P9: if (commit) begin
        w_nxt  = 64'($signed(prod) >>> 25);
        st_nxt = escu_pkg::S_P10;
      end
      escu_pkg::S_P10: if (commit) begin
        pres_nxt = 32'(64'($signed(psum) >>> 8) + p7_sh);
        st_nxt   = hum_next;
      end
      escu_pkg::S_H1: if (commit) begin
        ra_nxt = 32'($signed(h_base - prod32 + 32'd16384) >>> 15);
        st_nxt = escu_pkg::S_H2;
      end
      escu_pkg::S_H2: if (commit) begin
        rb_nxt = 32'($signed(prod32) >>> 10);
        st_nxt = escu_pkg::S_H3;
      end
      escu_pkg::S_H3: if (commit) begin
        rc_nxt = 32'($signed(prod32) >>> 11) + 32'd32768;
        st_nxt = escu_pkg::S_H4;
      end
      escu_pkg::S_H4: if (commit) begin
        rb_nxt = 32'($signed(prod32) >>> 10) + 32'd2097152;
        st_nxt = escu_pkg::S_H5;
      end
      escu_pkg::S_H5: if (commit) begin
        rb_nxt = 32'($signed(prod32 + 32'd8192) >>> 14);
        st_nxt = escu_pkg::S_H6;
      end
      escu_pkg::S_H6: if (commit) begin
        rc_nxt = prod32;
        st_nxt = escu_pkg::S_H7;
      end
      escu_pkg::S_H7: if (commit) begin
        rb_nxt = 32'($signed(prod32) >>> 7);
        st_nxt = escu_pkg::S_H8;
      end
      escu_pkg::S_H8: if (commit) begin
        // Clamp to the valid range before the final scaling.
        if (xf[31]) begin
          hum_nxt = '0;
        end else if (xf > 32'd419430400) begin
          hum_nxt = 17'd102400;
        end else begin
          hum_nxt = xf[28:12];
        end
        st_nxt = escu_pkg::S_OUT;
      end
      escu_pkg::S_OUT: begin
        out_valid_nxt                  = 1'b1;
        out_data_nxt.temperature_centi = temp_r;
        out_data_nxt.pressure_q8       = pres_r;
        out_data_nxt.humidity_q10      = cfg.humidity_enable ? hum_r : 17'd0;
        st_nxt                         = escu_pkg::S_IDLE;
      end
      default: st_nxt = escu_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= escu_pkg::S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      raw_p_r <= q_item.raw_pressure;
      raw_t_r <= q_item.raw_temperature;
      raw_h_r <= q_item.raw_humidity;
    end
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    rc_r       <= rc_nxt;
    tf_r       <= tf_nxt;
    temp_r     <= temp_nxt;
    pres_r     <= pres_nxt;
    hum_r      <= hum_nxt;
    sq_r       <= sq_nxt;
    v2_r       <= v2_nxt;
    w_r        <= w_nxt;
    dv_r       <= dv_nxt;
    p_r        <= p_nxt;
    out_data_r <= out_data_nxt;
  end

  `ESCU_ASSERT_NOW(a_mul_free, mul_start, !mul_busy, "multiplier started while busy")
  `ESCU_ASSERT_NOW(a_div_state, div_done, st_r == escu_pkg::S_DIV, "divider done out of step")
  `ESCU_ASSERT_NEXT(a_out_pulse, out_valid_r, !out_valid_r, "result strobe longer than one cycle")
  `ESCU_ASSERT_NOW(a_pop_valid, q_pop, q_valid && st_r == escu_pkg::S_IDLE, "pop without item")

endmodule

FILE: src/environment_sensor_compensation_unit.sv
// An item runs through 22 multiply steps and a division before its result strobe,
// fewer when the pressure divisor is zero (skips division and four multiplies) or
// humidity is disabled. The engine takes no new item until the last one is through;
// a queue of QUEUE_DEPTH items takes new items meanwhile.
// Synchronous active-low reset empties the queue, idles the engine and clears
// all calibration registers to zero.
module environment_sensor_compensation_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  escu_pkg::escu_in_t                   in_data,
  output logic                                out_valid,
  output escu_pkg::escu_out_t                  out_data,
  input  logic                                cfg_we,
  input  logic [escu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [escu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  escu_pkg::escu_cfg_t cfg_r;
  logic                q_valid, q_pop;
  escu_pkg::escu_in_t   q_item;

  // Calibration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        escu_pkg::CFG_TEMP_CALIB:       cfg_r.temp_calib       <= cfg_data[47:0];
        escu_pkg::CFG_PRESS_CALIB_LOW:  cfg_r.press_calib_low  <= cfg_data;
        escu_pkg::CFG_PRESS_CALIB_HIGH: cfg_r.press_calib_high <= cfg_data;
        escu_pkg::CFG_PRESS_CALIB_LAST: cfg_r.press_calib_last <= cfg_data[15:0];
        escu_pkg::CFG_HUM_CALIB:        cfg_r.hum_calib        <= cfg_data;
        escu_pkg::CFG_HUMIDITY_ENABLE:  cfg_r.humidity_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  escu_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  escu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: tb/sv/environment_sensor_compensation_unit_checker.sv
// Result checker for the environment sensor compensation unit.
// Watches accepted items and config writes, predicts each compensated result
// and compares it with the strobed output. Depends on escu_pkg.
`timescale 1ns / 1ps

module environment_sensor_compensation_unit_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  escu_pkg::escu_in_t              in_data,
  input  logic                            out_valid,
  input  escu_pkg::escu_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [escu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [escu_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  // Shadow copy of the calibration registers.
  logic [47:0] temp_cal;
  logic [63:0] press_lo;
  logic [63:0] press_hi;
  logic [15:0] press_p9;
  logic [63:0] hum_cal;
  logic        hum_en;

  escu_pkg::escu_out_t expected_results[$];

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int n);
    return 64'($signed(x) >>> n);
  endfunction

  // Signed 64-bit quotient, truncating toward zero, wrapping on overflow.
  function automatic logic [63:0] div_trunc64(logic [63:0] n, logic [63:0] d);
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic escu_pkg::escu_out_t compensate(escu_pkg::escu_in_t s);
    escu_pkg::escu_out_t r;
    logic [31:0] ap, at, ah, t1, t2, t3, a, dd, b, tfine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, pr;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb;
    ap = 32'(s.raw_pressure);
    at = 32'(s.raw_temperature);
    ah = 32'(s.raw_humidity);
    // Fine temperature and centidegrees.
    t1 = 32'(temp_cal[15:0]);
    t2 = 32'($signed(temp_cal[31:16]));
    t3 = 32'($signed(temp_cal[47:32]));
    a = sra32(((at >> 3) - (t1 << 1)) * t2, 11);
    dd = (at >> 4) - t1;
    b = sra32(sra32(dd * dd, 12) * t3, 14);
    tfine = a + b;
    r.temperature_centi = sra32(tfine * 32'd5 + 32'd128, 8);
    // Pressure in 64-bit arithmetic.
    p1 = 64'(press_lo[15:0]);
    p2 = 64'($signed(press_lo[31:16]));
    p3 = 64'($signed(press_lo[47:32]));
    p4 = 64'($signed(press_lo[63:48]));
    p5 = 64'($signed(press_hi[15:0]));
    p6 = 64'($signed(press_hi[31:16]));
    p7 = 64'($signed(press_hi[47:32]));
    p8 = 64'($signed(press_hi[63:48]));
    p9 = 64'($signed(press_p9));
    v1 = 64'($signed(tfine)) - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
    pr = '0;
    if (v1 != 0) begin
      p = 64'd1048576 - 64'(ap);
      p = div_trunc64(((p << 31) - v2) * 64'd3125, v1);
      v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
      v2 = sra64(p8 * p, 19);
      pr = sra64(p + v1 + v2, 8) + (p7 << 4);
    end
    r.pressure_q8 = pr[31:0];
    // Humidity in 32-bit arithmetic, clamped before the last shift.
    r.humidity_q10 = '0;
    if (hum_en) begin
      h1 = 32'(hum_cal[7:0]);
      h2 = 32'($signed(hum_cal[23:8]));
      h3 = 32'(hum_cal[31:24]);
      h4 = 32'($signed(hum_cal[43:32]));
      h5 = 32'($signed(hum_cal[55:44]));
      h6 = 32'($signed(hum_cal[63:56]));
      x = tfine - 32'd76800;
      ha = sra32((ah << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
      hb = sra32(sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768), 10) + 32'd2097152;
      hb = sra32(hb * h2 + 32'd8192, 14);
      x = ha * hb;
      x = x - sra32(sra32(sra32(x, 15) * sra32(x, 15), 7) * h1, 4);
      if (x[31]) x = '0;
      else if (x > 32'd419430400) x = 32'd419430400;
      r.humidity_q10 = 17'(x >> 12);
    end
    return r;
  endfunction

  // Track config, predict on acceptance, compare on strobe.
  always @(posedge clk) begin
    escu_pkg::escu_out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      temp_cal <= '0;
      press_lo <= '0;
      press_hi <= '0;
      press_p9 <= '0;
      hum_cal <= '0;
      hum_en <= 1'b0;
      expected_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          escu_pkg::CFG_TEMP_CALIB:       temp_cal <= cfg_data[47:0];
          escu_pkg::CFG_PRESS_CALIB_LOW:  press_lo <= cfg_data;
          escu_pkg::CFG_PRESS_CALIB_HIGH: press_hi <= cfg_data;
          escu_pkg::CFG_PRESS_CALIB_LAST: press_p9 <= cfg_data[15:0];
          escu_pkg::CFG_HUM_CALIB:        hum_cal <= cfg_data;
          escu_pkg::CFG_HUMIDITY_ENABLE:  hum_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) expected_results.push_back(compensate(in_data));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errs = errs + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi expected %0d actual %0d",
                   want.temperature_centi, out_data.temperature_centi);
            errs = errs + 1;
          end
          if (out_data.pressure_q8 !== want.pressure_q8) begin
            $error("pressure_q8 expected %0d actual %0d",
                   want.pressure_q8, out_data.pressure_q8);
            errs = errs + 1;
          end
          if (out_data.humidity_q10 !== want.humidity_q10) begin
            $error("humidity_q10 expected %0d actual %0d",
                   want.humidity_q10, out_data.humidity_q10);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_results.size();
    end
  end

endmodule

FILE: tb/sv/environment_sensor_compensation_unit_tb.sv
// Top of the compensation unit testbench: clock, reset, stimulus, verdict.
// Uses escu_pkg, the unit and environment_sensor_compensation_unit_checker.
`timescale 1ns / 1ps

module environment_sensor_compensation_unit_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 400;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  escu_pkg::escu_in_t              in_data;
  logic                            out_valid;
  escu_pkg::escu_out_t             out_data;
  logic                            cfg_we;
  logic [escu_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [escu_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              fail_count;
  int                              pending;
  int                              quiet_cycles;

  environment_sensor_compensation_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  environment_sensor_compensation_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: too long with no item accepted, no result and no register write ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL environment_sensor_compensation_unit");
      $finish;
    end
  end

  // One register write, after which the port idles before the task returns.
  task automatic write_reg(logic [escu_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every prediction is matched, then let the engine settle.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Present one sample and hold it until it is taken; start stays high on return
  // so that the next item can follow directly.
  task automatic send_sample(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh, bit gaps);
    int unsigned idle;
    idle = gaps ? $urandom_range(0, 3) : 0;
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_data <= '{raw_pressure: rp, raw_temperature: rt, raw_humidity: rh};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Program a calibration set: nominal-like values with random spread.
  task automatic load_nominal(bit hum_on);
    logic [15:0] t1, p1;
    t1 = 16'(27000 + $urandom_range(0, 2000));
    p1 = 16'(36000 + $urandom_range(0, 2000));
    write_reg(escu_pkg::CFG_TEMP_CALIB, {16'(-1000 + $urandom_range(0, 200)),
                                         16'(26000 + $urandom_range(0, 1000)), t1});
    write_reg(escu_pkg::CFG_PRESS_CALIB_LOW, {16'(7000 + $urandom_range(0, 2000)),
                                              16'(3000 + $urandom_range(0, 1000)),
                                              16'(-10600 + $urandom_range(0, 200)), p1});
    write_reg(escu_pkg::CFG_PRESS_CALIB_HIGH, {16'(-12000 + $urandom_range(0, 200)),
                                               16'(15000 + $urandom_range(0, 800)),
                                               16'(-7 + $urandom_range(0, 14)),
                                               16'(-200 + $urandom_range(0, 200))});
    write_reg(escu_pkg::CFG_PRESS_CALIB_LAST, 64'(16'(4000 + $urandom_range(0, 2000))));
    write_reg(escu_pkg::CFG_HUM_CALIB, {8'(30), 12'(50), 12'(320 + $urandom_range(0, 40)),
                                        8'(0), 16'(360 + $urandom_range(0, 40)), 8'(75)});
    write_reg(escu_pkg::CFG_HUMIDITY_ENABLE, 64'(hum_on));
  endtask

  task automatic load_random();
    write_reg(escu_pkg::CFG_TEMP_CALIB, {$urandom, $urandom});
    write_reg(escu_pkg::CFG_PRESS_CALIB_LOW, {$urandom, $urandom});
    write_reg(escu_pkg::CFG_PRESS_CALIB_HIGH, {$urandom, $urandom});
    write_reg(escu_pkg::CFG_PRESS_CALIB_LAST, {$urandom, $urandom});
    write_reg(escu_pkg::CFG_HUM_CALIB, {$urandom, $urandom});
    write_reg(escu_pkg::CFG_HUMIDITY_ENABLE, {$urandom, $urandom});
  endtask

  task automatic random_samples(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        send_sample(20'($urandom), 20'($urandom), 16'($urandom), 1'b1);
      else
        send_sample(20'(250000 + $urandom_range(0, 300000)),
                    20'(480000 + $urandom_range(0, 120000)),
                    16'(20000 + $urandom_range(0, 30000)), $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration: zero divisor, humidity disabled.
    send_sample('0, '0, '0, 1'b0);
    send_sample('1, '1, '1, 1'b0);
    drain();

    // Typical calibration with field extremes, humidity on.
    load_nominal(1'b1);
    send_sample('0, '0, '0, 1'b0);
    send_sample('1, '1, '1, 1'b0);
    send_sample(20'd415148, 20'd519888, 16'd29000, 1'b0);
    send_sample(20'd415148, 20'd519888, 16'hFFFF, 1'b0);
    send_sample(20'd415148, 20'd519888, 16'h0000, 1'b0);
    drain();

    // Humidity disabled.
    write_reg(escu_pkg::CFG_HUMIDITY_ENABLE, 64'd0);
    send_sample(20'd300000, 20'd500000, 16'd30000, 1'b0);
    drain();

    // Register extremes: all ones, then most negative fields.
    write_reg(escu_pkg::CFG_TEMP_CALIB, '1);
    write_reg(escu_pkg::CFG_PRESS_CALIB_LOW, '1);
    write_reg(escu_pkg::CFG_PRESS_CALIB_HIGH, '1);
    write_reg(escu_pkg::CFG_PRESS_CALIB_LAST, '1);
    write_reg(escu_pkg::CFG_HUM_CALIB, '1);
    write_reg(escu_pkg::CFG_HUMIDITY_ENABLE, '1);
    send_sample('1, '1, '1, 1'b0);
    send_sample('0, '0, '0, 1'b0);
    drain();
    write_reg(escu_pkg::CFG_TEMP_CALIB, 64'h8000_8000_FFFF);
    write_reg(escu_pkg::CFG_PRESS_CALIB_LOW, 64'h8000_8000_8000_FFFF);
    write_reg(escu_pkg::CFG_PRESS_CALIB_HIGH, 64'h8000_8000_8000_8000);
    write_reg(escu_pkg::CFG_PRESS_CALIB_LAST, 64'h8000);
    write_reg(escu_pkg::CFG_HUM_CALIB, 64'h80_800_800_FF_8000_FF);
    send_sample('1, '0, 16'h8000, 1'b0);
    send_sample('0, '1, 16'h7FFF, 1'b0);
    drain();

    // Random items over several calibration phases.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase % 3 == 2) load_random();
      else load_nominal(phase != 4);
      random_samples(73);
      drain();
    end

    drain();
    if (fail_count == 0) $display("PASS environment_sensor_compensation_unit");
    else $display("FAIL environment_sensor_compensation_unit");
    $finish;
  end

endmodule
